// ----- rtl/core/fhfe_pkg.sv -----
package fhfe_pkg;

	// byte position counter, saturating
	localparam int POS_W = 9;
	localparam logic [POS_W-1:0] POS_MAX = 9'd511;

	// ethernet header positions and network header offsets
	localparam logic [POS_W-1:0] POS_ETYPE_HI = 9'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO = 9'd13;
	localparam logic [4:0] OFF_PLAIN = 5'd14;
	localparam logic [4:0] OFF_VLAN  = 5'd18;
	localparam logic [4:0] OFF_PPPOE = 5'd22;

	// ethertype bytes
	localparam logic [7:0] ETYPE_VLAN_HI  = 8'h81;
	localparam logic [7:0] ETYPE_VLAN_LO  = 8'h00;
	localparam logic [7:0] ETYPE_PPPOE_HI = 8'h88;
	localparam logic [3:0] ETYPE_PPPOE_NIB = 4'h6;

	// ip versions and header sizes
	localparam logic [3:0] IP_VER_4 = 4'h4;
	localparam logic [3:0] IP_VER_6 = 4'h6;
	localparam logic [5:0] V6_HDR_LEN = 6'd40;

	// wire length floor and tcp flags of interest (syn, fin)
	localparam logic [15:0] MIN_WIRE_LEN = 16'd34;
	localparam logic [7:0] TCP_SYN_FIN = 8'h03;

	// ip protocol numbers
	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IPV4_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IPV6_EN = 2'd1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT      = 3'd1,
		ST_NOT_IP     = 3'd2,
		ST_FAMILY_OFF = 3'd3,
		ST_BAD_PROTO  = 3'd4,
		ST_TCP_MIDDLE = 3'd5,
		ST_TRUNCATED  = 3'd6
	} status_t;

	// frame state after the current byte, handed from parser to judge
	typedef struct packed {
		logic [POS_W-1:0] count;
		logic [4:0]       net_off;
		logic [7:0]       ver_ihl;
		logic [7:0]       proto;
		logic [127:0]     src_addr;
		logic [127:0]     dst_addr;
		logic [31:0]      ports;
		logic [7:0]       tcp_flags;
		logic             ver_seen;
	} frame_state_t;

endpackage

// ----- rtl/core/fhfe_if.sv -----
// frame byte channel
interface fhfe_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic [15:0] wire_length;
	logic        end_of_frame;

	modport source (output valid, frame_byte, wire_length, end_of_frame, input ready);
	modport sink (input valid, frame_byte, wire_length, end_of_frame, output ready);
endinterface

// flow record channel
interface fhfe_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        is_ipv4;
	logic [7:0]  protocol;
	logic [31:0] src_ipv4;
	logic [31:0] dst_ipv4;
	logic [63:0] src_ipv6_upper;
	logic [63:0] src_ipv6_lower;
	logic [63:0] dst_ipv6_upper;
	logic [63:0] dst_ipv6_lower;
	logic [15:0] source_port;
	logic [15:0] destination_port;

	modport source (output valid, status, is_ipv4, protocol, src_ipv4, dst_ipv4,
		src_ipv6_upper, src_ipv6_lower, dst_ipv6_upper, dst_ipv6_lower,
		source_port, destination_port, input ready);
	modport sink (input valid, status, is_ipv4, protocol, src_ipv4, dst_ipv4,
		src_ipv6_upper, src_ipv6_lower, dst_ipv6_upper, dst_ipv6_lower,
		source_port, destination_port, output ready);
endinterface

// configuration write channel
interface fhfe_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/frame_header_flow_extractor_top.sv -----
// Frame header flow extractor: parses a captured Ethernet frame byte by byte
// (optional VLAN tag or PPPoE/PPP header, then IPv4 or IPv6, then TCP/UDP ports)
// and emits one flow record with a status at the last byte of each frame.
// Channels: frame_in takes one item per byte (frame_byte, wire_length,
// end_of_frame); record_out gives one item per frame; cfg writes the two
// family enables (index 0 ipv4, index 1 ipv6), always ready.
// Throughput: one byte item per cycle, including back-to-back frames, unless a last byte meets a stalled record.
// Path: the last byte of a frame is accepted into the input register, then its
// record is loaded into the record register; the parse logic
// between them is a single pass over the registered byte and the frame state.
// Only the first CAPTURE_BYTES bytes of a frame are parsed; later bytes are
// counted and otherwise dropped.
// Stall: while a record waits on record_out, bytes keep flowing until the next
// last byte reaches the input register; frame_in then drops ready until the
// waiting record is taken.
// Reset: clears the frame state and the valid flags; both families enabled.
module frame_header_flow_extractor_top #(
	parameter int CAPTURE_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	fhfe_in_if.sink     frame_in,
	fhfe_out_if.source  record_out,
	fhfe_cfg_if.sink    cfg
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] len_s1;
	logic        eof_s1;
	logic        ipv4_en_q;
	logic        ipv6_en_q;
	logic        advance;
	logic        busy;

	fhfe_pkg::frame_state_t frame_st;

	// input stage moves on unless a last byte meets a stalled record
	assign advance        = valid_s1 && !(eof_s1 && busy);
	assign frame_in.ready = !valid_s1 || advance;
	assign cfg.ready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (frame_in.valid && frame_in.ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1 <= frame_in.frame_byte;
			len_s1  <= frame_in.wire_length;
			eof_s1  <= frame_in.end_of_frame;
		end
	end

	// family enable registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv4_en_q <= 1'b1;
			ipv6_en_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == fhfe_pkg::CFG_IPV4_EN)
				ipv4_en_q <= cfg.data;
			else if (cfg.index == fhfe_pkg::CFG_IPV6_EN)
				ipv6_en_q <= cfg.data;
		end
	end

	fhfe_parse #(
		.CAPTURE_BYTES(CAPTURE_BYTES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (advance),
		.frame_byte   (byte_s1),
		.end_of_frame (eof_s1),
		.frame_st     (frame_st)
	);

	fhfe_judge u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && eof_s1),
		.frame_st    (frame_st),
		.wire_length (len_s1),
		.ipv4_en     (ipv4_en_q),
		.ipv6_en     (ipv6_en_q),
		.busy        (busy),
		.record_out  (record_out)
	);

	// a last byte held against a stalled record blocks new input
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && eof_s1 && busy) |-> !frame_in.ready)
		else $error("input accepted while last byte is blocked");

endmodule

// ----- rtl/core/fhfe_parse.sv -----
module fhfe_parse #(
	parameter int CAPTURE_BYTES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            frame_byte,
	input  logic                  end_of_frame,
	output fhfe_pkg::frame_state_t frame_st
);

	localparam logic [fhfe_pkg::POS_W-1:0] CAP_LIMIT = fhfe_pkg::POS_W'(CAPTURE_BYTES);

	logic [fhfe_pkg::POS_W-1:0] pos_q;
	logic [7:0]   etype_hi_q;
	logic [4:0]   off_q;
	logic [7:0]   ver_ihl_q;
	logic [7:0]   proto_q;
	logic [127:0] src_q;
	logic [127:0] dst_q;
	logic [31:0]  ports_q;
	logic [7:0]   flags_q;
	logic         seen_q;

	logic [fhfe_pkg::POS_W-1:0] pos_n;
	logic [7:0] etype_hi_n;

	// next state from the current byte
	always_comb begin
		logic [fhfe_pkg::POS_W-1:0] r;
		logic [fhfe_pkg::POS_W-1:0] q;
		logic [7:0] vi;
		logic       is4;
		logic       is6;
		logic [5:0] l4;
		logic       src_we;
		logic       dst_we;
		logic [3:0] src_k;
		logic [3:0] dst_k;

		pos_n      = (pos_q < fhfe_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;
		etype_hi_n = etype_hi_q;
		frame_st.net_off   = off_q;
		frame_st.ver_ihl   = ver_ihl_q;
		frame_st.proto     = proto_q;
		frame_st.src_addr  = src_q;
		frame_st.dst_addr  = dst_q;
		frame_st.ports     = ports_q;
		frame_st.tcp_flags = flags_q;
		frame_st.ver_seen  = seen_q;
		frame_st.count     = (pos_n < CAP_LIMIT) ? pos_n : CAP_LIMIT;
		r      = '0;
		q      = '0;
		vi     = ver_ihl_q;
		is4    = 1'b0;
		is6    = 1'b0;
		l4     = '0;
		src_we = 1'b0;
		dst_we = 1'b0;
		src_k  = '0;
		dst_k  = '0;

		if (pos_q < CAP_LIMIT) begin
			// ethertype and tag skip
			if (pos_q == fhfe_pkg::POS_ETYPE_HI)
				etype_hi_n = frame_byte;
			if (pos_q == fhfe_pkg::POS_ETYPE_LO) begin
				if (etype_hi_q == fhfe_pkg::ETYPE_VLAN_HI && frame_byte == fhfe_pkg::ETYPE_VLAN_LO)
					frame_st.net_off = fhfe_pkg::OFF_VLAN;
				else if (etype_hi_q == fhfe_pkg::ETYPE_PPPOE_HI
						&& frame_byte[7:4] == fhfe_pkg::ETYPE_PPPOE_NIB)
					frame_st.net_off = fhfe_pkg::OFF_PPPOE;
				else
					frame_st.net_off = fhfe_pkg::OFF_PLAIN;
			end

			// network header bytes
			if (pos_q >= {4'b0, frame_st.net_off}) begin
				r = pos_q - {4'b0, frame_st.net_off};
				if (r == '0) begin
					vi = frame_byte;
					frame_st.ver_ihl  = frame_byte;
					frame_st.ver_seen = 1'b1;
				end
				is4 = (vi[7:4] == fhfe_pkg::IP_VER_4);
				is6 = (vi[7:4] == fhfe_pkg::IP_VER_6);
				if (is4) begin
					if (r == 9'd9)
						frame_st.proto = frame_byte;
					src_we = (r >= 9'd12 && r <= 9'd15);
					src_k  = r[3:0];
					dst_we = (r >= 9'd16 && r <= 9'd19);
					dst_k  = 4'(r - 9'd4);
					l4     = {vi[3:0], 2'b00};
				end else if (is6) begin
					if (r == 9'd6)
						frame_st.proto = frame_byte;
					src_we = (r >= 9'd8 && r <= 9'd23);
					src_k  = 4'(r - 9'd8);
					dst_we = (r >= 9'd24 && r <= 9'd39);
					dst_k  = 4'(r - 9'd24);
					l4     = fhfe_pkg::V6_HDR_LEN;
				end
				for (int i = 0; i < 16; i++) begin
					if (src_we && src_k == 4'(i))
						frame_st.src_addr[127-8*i -: 8] = frame_byte;
					if (dst_we && dst_k == 4'(i))
						frame_st.dst_addr[127-8*i -: 8] = frame_byte;
				end

				// transport header bytes
				if ((is4 || is6) && r >= {3'b0, l4}) begin
					q = r - {3'b0, l4};
					for (int j = 0; j < 4; j++) begin
						if (q == fhfe_pkg::POS_W'(j))
							frame_st.ports[31-8*j -: 8] = frame_byte;
					end
					if (q == 9'd13)
						frame_st.tcp_flags = frame_byte;
				end
			end
		end
	end

	// frame state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			etype_hi_q <= '0;
			off_q      <= fhfe_pkg::OFF_PLAIN;
			ver_ihl_q  <= '0;
			proto_q    <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			ports_q    <= '0;
			flags_q    <= '0;
			seen_q     <= 1'b0;
		end else if (take) begin
			if (end_of_frame) begin
				pos_q      <= '0;
				etype_hi_q <= '0;
				off_q      <= fhfe_pkg::OFF_PLAIN;
				ver_ihl_q  <= '0;
				proto_q    <= '0;
				src_q      <= '0;
				dst_q      <= '0;
				ports_q    <= '0;
				flags_q    <= '0;
				seen_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				etype_hi_q <= etype_hi_n;
				off_q      <= frame_st.net_off;
				ver_ihl_q  <= frame_st.ver_ihl;
				proto_q    <= frame_st.proto;
				src_q      <= frame_st.src_addr;
				dst_q      <= frame_st.dst_addr;
				ports_q    <= frame_st.ports;
				flags_q    <= frame_st.tcp_flags;
				seen_q     <= frame_st.ver_seen;
			end
		end
	end

	// state is back to reset after the last byte of a frame
	a_clear_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(take && end_of_frame) |=> (pos_q == '0 && !seen_q && off_q == fhfe_pkg::OFF_PLAIN))
		else $error("frame state not cleared after last byte");

	// version byte is only captured once the network header is reached
	a_seen_past_offset: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (pos_q > {4'b0, off_q}))
		else $error("version byte seen before network offset");

endmodule

// ----- rtl/core/fhfe_judge.sv -----
module fhfe_judge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  fhfe_pkg::frame_state_t frame_st,
	input  logic [15:0]            wire_length,
	input  logic                   ipv4_en,
	input  logic                   ipv6_en,
	output logic                   busy,
	fhfe_out_if.source             record_out
);

	fhfe_pkg::status_t status_c;
	logic              v4_c;

	// frame checks in priority order
	always_comb begin
		logic [9:0] n;
		logic [9:0] off;
		logic [9:0] l4;
		logic       is4;
		logic       is6;
		logic       tcp;
		logic       udp;

		n   = {1'b0, frame_st.count};
		off = {5'b0, frame_st.net_off};
		is4 = (frame_st.ver_ihl[7:4] == fhfe_pkg::IP_VER_4);
		is6 = (frame_st.ver_ihl[7:4] == fhfe_pkg::IP_VER_6);
		l4  = is4 ? {4'b0, frame_st.ver_ihl[3:0], 2'b00} : {4'b0, fhfe_pkg::V6_HDR_LEN};
		tcp = (frame_st.proto == fhfe_pkg::PROTO_TCP);
		udp = (frame_st.proto == fhfe_pkg::PROTO_UDP);
		v4_c = is4;

		if (wire_length < fhfe_pkg::MIN_WIRE_LEN)
			status_c = fhfe_pkg::ST_SHORT;
		else if (n < 10'd14 || !frame_st.ver_seen || off >= n)
			status_c = fhfe_pkg::ST_TRUNCATED;
		else if (!is4 && !is6)
			status_c = fhfe_pkg::ST_NOT_IP;
		else if (off + (is4 ? 10'd9 : 10'd6) >= n)
			status_c = fhfe_pkg::ST_TRUNCATED;
		else if (is4 ? !ipv4_en : !ipv6_en)
			status_c = fhfe_pkg::ST_FAMILY_OFF;
		else if ((tcp || udp) && off + l4 + 10'd3 >= n)
			status_c = fhfe_pkg::ST_TRUNCATED;
		else if (tcp && off + l4 + 10'd13 >= n)
			status_c = fhfe_pkg::ST_TRUNCATED;
		else if (tcp && (frame_st.tcp_flags & fhfe_pkg::TCP_SYN_FIN) == 8'h00)
			status_c = fhfe_pkg::ST_TCP_MIDDLE;
		else if (!tcp && !udp && frame_st.proto != fhfe_pkg::PROTO_ICMP
				&& frame_st.proto != fhfe_pkg::PROTO_ICMPV6)
			status_c = fhfe_pkg::ST_BAD_PROTO;
		else if (off + (is4 ? 10'd19 : 10'd39) >= n)
			status_c = fhfe_pkg::ST_TRUNCATED;
		else
			status_c = fhfe_pkg::ST_OK;
	end

	assign busy = record_out.valid && !record_out.ready;

	// record valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			record_out.valid <= 1'b0;
		else if (load)
			record_out.valid <= 1'b1;
		else if (record_out.ready)
			record_out.valid <= 1'b0;
	end

	// record payload, zeroed where the status or family says so
	always_ff @(posedge clk) begin
		if (load) begin
			logic ok;
			logic ports_ok;
			ok       = (status_c == fhfe_pkg::ST_OK);
			ports_ok = ok && (frame_st.proto == fhfe_pkg::PROTO_TCP
				|| frame_st.proto == fhfe_pkg::PROTO_UDP);
			record_out.status           <= status_c;
			record_out.is_ipv4          <= ok && v4_c;
			record_out.protocol         <= ok ? frame_st.proto : 8'h00;
			record_out.src_ipv4         <= ok ? frame_st.src_addr[31:0] : 32'h0;
			record_out.dst_ipv4         <= ok ? frame_st.dst_addr[31:0] : 32'h0;
			record_out.src_ipv6_upper   <= (ok && !v4_c) ? frame_st.src_addr[127:64] : 64'h0;
			record_out.src_ipv6_lower   <= (ok && !v4_c) ? frame_st.src_addr[63:0] : 64'h0;
			record_out.dst_ipv6_upper   <= (ok && !v4_c) ? frame_st.dst_addr[127:64] : 64'h0;
			record_out.dst_ipv6_lower   <= (ok && !v4_c) ? frame_st.dst_addr[63:0] : 64'h0;
			record_out.source_port      <= ports_ok ? frame_st.ports[31:16] : 16'h0;
			record_out.destination_port <= ports_ok ? frame_st.ports[15:0] : 16'h0;
		end
	end

	// a new record never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("record loaded while previous one stalled");

	// rejected records carry only their status
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(record_out.valid && record_out.status != fhfe_pkg::ST_OK) |->
		(record_out.protocol == 8'h00 && record_out.src_ipv4 == 32'h0
			&& record_out.source_port == 16'h0 && !record_out.is_ipv4))
		else $error("rejected record has nonzero fields");

	// ipv4 records leave the ipv6 address fields empty
	a_v4_no_v6: assert property (@(posedge clk) disable iff (!arst_n)
		(record_out.valid && record_out.is_ipv4) |->
		(record_out.src_ipv6_upper == 64'h0 && record_out.dst_ipv6_lower == 64'h0))
		else $error("ipv4 record carries ipv6 address");

endmodule

// ----- test/tb_frame_header_flow_extractor_top.sv -----
module tb_frame_header_flow_extractor_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPTURE = 128;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	// tcp flag values and a protocol the block must reject
	localparam logic [7:0] TCP_FIN = 8'h01;
	localparam logic [7:0] TCP_SYN = 8'h02;
	localparam logic [7:0] TCP_ACK = 8'h10;
	localparam logic [7:0] PROTO_RESERVED = 8'd255;

	typedef enum {ENC_PLAIN, ENC_VLAN, ENC_PPPOE, ENC_OTHER} encap_t;
	typedef bit [7:0] byte_q_t[$];

	typedef struct {
		bit [2:0]  status;
		bit        is_ipv4;
		bit [7:0]  protocol;
		bit [31:0] src_ipv4;
		bit [31:0] dst_ipv4;
		bit [63:0] src_ipv6_upper;
		bit [63:0] src_ipv6_lower;
		bit [63:0] dst_ipv6_upper;
		bit [63:0] dst_ipv6_lower;
		bit [15:0] source_port;
		bit [15:0] destination_port;
	} flow_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	fhfe_in_if  frame_in();
	fhfe_out_if record_out();
	fhfe_cfg_if cfg();

	frame_header_flow_extractor_top #(.CAPTURE_BYTES(CAPTURE)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.record_out (record_out),
		.cfg        (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// header parser state of the predictor
	bit [8:0]   byte_pos;
	bit [15:0]  etype_word;
	bit [4:0]   net_off;
	bit [7:0]   ver_ihl;
	bit [7:0]   l3_proto;
	bit [127:0] src_addr;
	bit [127:0] dst_addr;
	bit [31:0]  port_word;
	bit [7:0]   tcp_flags;
	bit         ver_seen;
	bit         v4_en;
	bit         v6_en;

	flow_rec_t flow_record_q[$];
	int errors;
	int records_seen;
	int items_sent;
	int frames_sent;

	// traffic shaping controls
	bit src_idle_on;
	bit sink_idle_on;
	int hold_len;
	int quiet_cycles;

	function automatic void clear_frame_state();
		byte_pos = '0;
		etype_word = '0;
		net_off = fhfe_pkg::OFF_PLAIN;
		ver_ihl = '0;
		l3_proto = '0;
		src_addr = '0;
		dst_addr = '0;
		port_word = '0;
		tcp_flags = '0;
		ver_seen = 1'b0;
	endfunction

	// fold one captured byte into the header state
	function automatic void parse_header_byte(input int p, input bit [7:0] b);
		int r;
		int l4;
		int q;
		bit [7:0] vi;
		if (p == int'(fhfe_pkg::POS_ETYPE_HI))
			etype_word = {b, 8'h00};
		if (p == int'(fhfe_pkg::POS_ETYPE_LO)) begin
			etype_word[7:0] = b;
			if (etype_word == {fhfe_pkg::ETYPE_VLAN_HI, fhfe_pkg::ETYPE_VLAN_LO})
				net_off = fhfe_pkg::OFF_VLAN;
			else if (etype_word[15:8] == fhfe_pkg::ETYPE_PPPOE_HI
					&& b[7:4] == fhfe_pkg::ETYPE_PPPOE_NIB)
				net_off = fhfe_pkg::OFF_PPPOE;
			else
				net_off = fhfe_pkg::OFF_PLAIN;
		end
		if (p < int'(net_off))
			return;
		r = p - int'(net_off);
		vi = (r == 0) ? b : ver_ihl;
		if (r == 0) begin
			ver_ihl = b;
			ver_seen = 1'b1;
		end
		if (vi[7:4] == fhfe_pkg::IP_VER_4) begin
			if (r == 9) l3_proto = b;
			if (r >= 12 && r <= 15) src_addr[127 - 8*r -: 8] = b;
			if (r >= 16 && r <= 19) dst_addr[127 - 8*(r-4) -: 8] = b;
			l4 = int'(vi[3:0]) * 4;
		end else if (vi[7:4] == fhfe_pkg::IP_VER_6) begin
			if (r == 6) l3_proto = b;
			if (r >= 8 && r <= 23) src_addr[127 - 8*(r-8) -: 8] = b;
			if (r >= 24 && r <= 39) dst_addr[127 - 8*(r-24) -: 8] = b;
			l4 = int'(fhfe_pkg::V6_HDR_LEN);
		end else begin
			return;
		end
		// l4 header, possibly overlapping a small ip header
		if (r >= l4) begin
			q = r - l4;
			if (q < 4) port_word[31 - 8*q -: 8] = b;
			if (q == 13) tcp_flags = b;
		end
	endfunction

	// status of the finished frame, checks in priority order
	function automatic fhfe_pkg::status_t frame_status(input int n, input int len);
		int off;
		int l4;
		bit v4;
		off = int'(net_off);
		if (len < int'(fhfe_pkg::MIN_WIRE_LEN)) return fhfe_pkg::ST_SHORT;
		if (n < int'(fhfe_pkg::OFF_PLAIN) || !ver_seen || off >= n)
			return fhfe_pkg::ST_TRUNCATED;
		if (ver_ihl[7:4] != fhfe_pkg::IP_VER_4 && ver_ihl[7:4] != fhfe_pkg::IP_VER_6)
			return fhfe_pkg::ST_NOT_IP;
		v4 = (ver_ihl[7:4] == fhfe_pkg::IP_VER_4);
		if (off + (v4 ? 9 : 6) >= n) return fhfe_pkg::ST_TRUNCATED;
		if (v4 ? !v4_en : !v6_en) return fhfe_pkg::ST_FAMILY_OFF;
		l4 = v4 ? int'(ver_ihl[3:0]) * 4 : int'(fhfe_pkg::V6_HDR_LEN);
		if (l3_proto == fhfe_pkg::PROTO_TCP || l3_proto == fhfe_pkg::PROTO_UDP) begin
			if (off + l4 + 3 >= n) return fhfe_pkg::ST_TRUNCATED;
			if (l3_proto == fhfe_pkg::PROTO_TCP) begin
				if (off + l4 + 13 >= n) return fhfe_pkg::ST_TRUNCATED;
				if ((tcp_flags & fhfe_pkg::TCP_SYN_FIN) == 8'h00)
					return fhfe_pkg::ST_TCP_MIDDLE;
			end
		end else if (l3_proto != fhfe_pkg::PROTO_ICMP && l3_proto != fhfe_pkg::PROTO_ICMPV6) begin
			return fhfe_pkg::ST_BAD_PROTO;
		end
		if (off + (v4 ? 19 : 39) >= n) return fhfe_pkg::ST_TRUNCATED;
		return fhfe_pkg::ST_OK;
	endfunction

	// advance the predictor by one accepted byte item
	function automatic void predict_flow_byte(input bit [7:0] b, input bit [15:0] len,
		input bit eof);
		int n;
		bit v4;
		flow_rec_t rec;
		if (byte_pos < CAPTURE)
			parse_header_byte(int'(byte_pos), b);
		if (byte_pos < fhfe_pkg::POS_MAX)
			byte_pos++;
		if (!eof)
			return;
		n = (byte_pos < CAPTURE) ? int'(byte_pos) : CAPTURE;
		rec = '{default: '0};
		rec.status = frame_status(n, int'(len));
		if (rec.status == fhfe_pkg::ST_OK) begin
			v4 = (ver_ihl[7:4] == fhfe_pkg::IP_VER_4);
			rec.is_ipv4 = v4;
			rec.protocol = l3_proto;
			rec.src_ipv4 = src_addr[31:0];
			rec.dst_ipv4 = dst_addr[31:0];
			if (!v4) begin
				rec.src_ipv6_upper = src_addr[127:64];
				rec.src_ipv6_lower = src_addr[63:0];
				rec.dst_ipv6_upper = dst_addr[127:64];
				rec.dst_ipv6_lower = dst_addr[63:0];
			end
			if (l3_proto == fhfe_pkg::PROTO_TCP || l3_proto == fhfe_pkg::PROTO_UDP) begin
				rec.source_port = port_word[31:16];
				rec.destination_port = port_word[15:0];
			end
		end
		flow_record_q.push_back(rec);
		clear_frame_state();
	endfunction

	function automatic void check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want) begin
			$display("%0t: record %0d %s mismatch: expected %h, actual %h",
				$time, records_seen, name, want, got);
			errors++;
		end
	endfunction

	// compare each accepted record against the oldest prediction
	always @(posedge clk) begin
		flow_rec_t want;
		if (arst_n === 1'b1 && record_out.valid === 1'b1 && record_out.ready === 1'b1) begin
			if (flow_record_q.size() == 0) begin
				$display("%0t: unexpected record: expected none, actual status %0d",
					$time, record_out.status);
				errors++;
			end else begin
				want = flow_record_q.pop_front();
				check_field("status", record_out.status, want.status);
				check_field("is_ipv4", record_out.is_ipv4, want.is_ipv4);
				check_field("protocol", record_out.protocol, want.protocol);
				check_field("src_ipv4", record_out.src_ipv4, want.src_ipv4);
				check_field("dst_ipv4", record_out.dst_ipv4, want.dst_ipv4);
				check_field("src_ipv6_upper", record_out.src_ipv6_upper, want.src_ipv6_upper);
				check_field("src_ipv6_lower", record_out.src_ipv6_lower, want.src_ipv6_lower);
				check_field("dst_ipv6_upper", record_out.dst_ipv6_upper, want.dst_ipv6_upper);
				check_field("dst_ipv6_lower", record_out.dst_ipv6_lower, want.dst_ipv6_lower);
				check_field("source_port", record_out.source_port, want.source_port);
				check_field("destination_port", record_out.destination_port,
					want.destination_port);
			end
			records_seen++;
		end
	end

	// record sink: random stall bursts, or one long hold when asked
	initial begin
		int n;
		record_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len != 0) begin
				record_out.ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				record_out.ready <= 1'b0;
				n = int'($urandom_range(1, 4));
			end else begin
				record_out.ready <= 1'b1;
				n = 1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((frame_in.valid && frame_in.ready) || (record_out.valid && record_out.ready)
				|| (cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("frame_header_flow_extractor_top regression: fail");
				$finish;
			end
		end
	end

	// offer one byte item, with an optional gap in front of it
	task automatic send_byte(input bit [7:0] b, input bit [15:0] len, input bit eof);
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 4));
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.frame_byte <= b;
		frame_in.wire_length <= len;
		frame_in.end_of_frame <= eof;
		do @(posedge clk); while (frame_in.ready !== 1'b1);
		predict_flow_byte(b, len, eof);
		items_sent++;
	endtask

	task automatic send_frame(input byte_q_t f, input bit [15:0] len);
		foreach (f[i])
			send_byte(f[i], len, i == f.size() - 1);
		frames_sent++;
	endtask

	task automatic write_reg(input logic [fhfe_pkg::CFG_IDX_W-1:0] idx, input bit val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		if (idx == fhfe_pkg::CFG_IPV4_EN)
			v4_en = val;
		else if (idx == fhfe_pkg::CFG_IPV6_EN)
			v6_en = val;
	endtask

	// let every record out, then let the block settle to idle
	task automatic wait_drained();
		frame_in.valid <= 1'b0;
		while (flow_record_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// frame with mac header, encapsulation, ip header and l4 header
	function automatic byte_q_t build_frame(input encap_t enc, input bit [3:0] ver,
		input bit [3:0] ihl, input bit [7:0] proto, input bit [7:0] flags, input int extra);
		byte_q_t f;
		int l3;
		int l4;
		int hdr;
		bit [7:0] x;
		for (int i = 0; i < 12; i++) f.push_back(8'($urandom_range(0, 255)));
		case (enc)
			ENC_VLAN: begin
				f.push_back(fhfe_pkg::ETYPE_VLAN_HI);
				f.push_back(fhfe_pkg::ETYPE_VLAN_LO);
				repeat (4) f.push_back(8'($urandom_range(0, 255)));
			end
			ENC_PPPOE: begin
				f.push_back(fhfe_pkg::ETYPE_PPPOE_HI);
				f.push_back({fhfe_pkg::ETYPE_PPPOE_NIB, 4'($urandom_range(0, 15))});
				repeat (8) f.push_back(8'($urandom_range(0, 255)));
			end
			ENC_OTHER: begin
				// near misses of the tagged ethertypes
				x = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 1) != 0) begin
					f.push_back(fhfe_pkg::ETYPE_VLAN_HI);
					f.push_back(x);
				end else begin
					if (x[7:4] == fhfe_pkg::ETYPE_PPPOE_NIB) x[4] = ~x[4];
					f.push_back(fhfe_pkg::ETYPE_PPPOE_HI);
					f.push_back(x);
				end
			end
			default: begin
				x = 8'($urandom_range(0, 255));
				if (x == fhfe_pkg::ETYPE_VLAN_HI || x == fhfe_pkg::ETYPE_PPPOE_HI) x = ~x;
				f.push_back(x);
				f.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		l3 = f.size();
		if (ver == fhfe_pkg::IP_VER_4) begin
			l4 = int'(ihl) * 4;
			hdr = (l4 + 20 > 20) ? l4 + 20 : 20;
		end else if (ver == fhfe_pkg::IP_VER_6) begin
			l4 = int'(fhfe_pkg::V6_HDR_LEN);
			hdr = l4 + 20;
		end else begin
			l4 = 0;
			hdr = 20 + int'($urandom_range(0, 20));
		end
		repeat (hdr) f.push_back(8'($urandom_range(0, 255)));
		if (ver == fhfe_pkg::IP_VER_4 || ver == fhfe_pkg::IP_VER_6)
			f[l3 + l4 + 13] = flags;
		f[l3] = {ver, ihl};
		if (ver == fhfe_pkg::IP_VER_4)
			f[l3 + 9] = proto;
		else if (ver == fhfe_pkg::IP_VER_6)
			f[l3 + 6] = proto;
		repeat (extra) f.push_back(8'($urandom_range(0, 255)));
		return f;
	endfunction

	task automatic send_random_frame();
		byte_q_t f;
		encap_t enc;
		bit [3:0] ver;
		bit [3:0] ihl;
		bit [7:0] proto;
		bit [7:0] flags;
		bit [15:0] len;
		int extra;
		int sel;
		int cut;
		sel = int'($urandom_range(0, 9));
		if (sel < 5) enc = ENC_PLAIN;
		else if (sel < 7) enc = ENC_VLAN;
		else if (sel < 9) enc = ENC_PPPOE;
		else enc = ENC_OTHER;
		sel = int'($urandom_range(0, 19));
		if (sel < 9) ver = fhfe_pkg::IP_VER_4;
		else if (sel < 18) ver = fhfe_pkg::IP_VER_6;
		else ver = 4'($urandom_range(0, 15));
		ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
		sel = int'($urandom_range(0, 9));
		if (sel < 3) proto = fhfe_pkg::PROTO_TCP;
		else if (sel < 6) proto = fhfe_pkg::PROTO_UDP;
		else if (sel < 7) proto = fhfe_pkg::PROTO_ICMP;
		else if (sel < 8) proto = fhfe_pkg::PROTO_ICMPV6;
		else proto = 8'($urandom_range(0, 255));
		flags = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0) flags[$urandom_range(0, 1)] = 1'b1;
		sel = int'($urandom_range(0, 49));
		if (sel == 0) extra = int'($urandom_range(100, 450));
		else if (sel < 8) extra = int'($urandom_range(0, 60));
		else extra = int'($urandom_range(0, 8));
		f = build_frame(enc, ver, ihl, proto, flags, extra);
		// some frames lose their tail to the capture
		if ($urandom_range(0, 3) == 0) begin
			cut = int'($urandom_range(1, f.size()));
			f = f[0:cut-1];
		end
		sel = int'($urandom_range(0, 19));
		if (sel < 2) len = 16'($urandom_range(0, int'(fhfe_pkg::MIN_WIRE_LEN) - 1));
		else if (sel < 4) len = 16'($urandom_range(0, 65535));
		else len = 16'($urandom_range(int'(fhfe_pkg::MIN_WIRE_LEN), 1518));
		send_frame(f, len);
	endtask

	task automatic test_random_traffic(input int item_goal, input int frame_goal);
		int item_base;
		int frame_base;
		item_base = items_sent;
		frame_base = frames_sent;
		while (items_sent - item_base < item_goal || frames_sent - frame_base < frame_goal)
			send_random_frame();
	endtask

	task automatic test_directed_frames();
		byte_q_t f;
		// well-formed frames through each encapsulation, with tcp, icmpv6 and icmp
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_TCP,
			TCP_SYN, 0), 16'd60);
		send_frame(build_frame(ENC_PPPOE, fhfe_pkg::IP_VER_6, 4'd0, fhfe_pkg::PROTO_TCP,
			TCP_FIN, 0), 16'd90);
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_6, 4'd3, fhfe_pkg::PROTO_ICMPV6,
			8'h00, 2), 16'd80);
		send_frame(build_frame(ENC_VLAN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_ICMP,
			8'h00, 0), fhfe_pkg::MIN_WIRE_LEN);
		// short on the wire
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP,
			8'h00, 0), fhfe_pkg::MIN_WIRE_LEN - 16'd1);
		// not ip, bad protocol, tcp middle segment
		send_frame(build_frame(ENC_PLAIN, 4'h5, 4'd5, fhfe_pkg::PROTO_TCP, TCP_SYN, 0),
			16'd60);
		send_frame(build_frame(ENC_VLAN, fhfe_pkg::IP_VER_4, 4'd5, PROTO_RESERVED, 8'h00, 0),
			16'd60);
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_6, 4'd0, fhfe_pkg::PROTO_TCP,
			TCP_ACK, 0), 16'd90);
		// ihl extremes: l4 inside the ip header, and the longest header
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd0, fhfe_pkg::PROTO_UDP,
			8'h00, 0), 16'd60);
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd15, fhfe_pkg::PROTO_TCP,
			fhfe_pkg::TCP_SYN_FIN, 0), 16'd120);
		// capture ends at, and one byte before, the last needed byte
		f = build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP, 8'h00, 0);
		send_frame(f[0:37], 16'd60);
		send_frame(f[0:36], 16'd60);
		f = build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_TCP, TCP_FIN, 0);
		send_frame(f[0:47], 16'd60);
		send_frame(f[0:46], 16'd60);
		// tiny captures
		send_frame(f[0:0], 16'd60);
		send_frame(f[0:12], 16'd60);
		// ethertypes close to the tagged ones
		send_frame(build_frame(ENC_OTHER, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP,
			8'h00, 0), 16'd60);
		// long frame: bytes past capture and a saturated position
		send_frame(build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP,
			8'h00, 460), 16'd1500);
		// all ones and all zeros
		f = {};
		repeat (40) f.push_back(8'hFF);
		send_frame(f, 16'hFFFF);
		f = {};
		repeat (40) f.push_back(8'h00);
		send_frame(f, 16'd40);
	endtask

	// each family enable setting, including both off
	task automatic test_family_enables();
		bit [1:0] setting [3] = '{2'b10, 2'b01, 2'b00};
		byte_q_t f;
		foreach (setting[k]) begin
			wait_drained();
			write_reg(fhfe_pkg::CFG_IPV4_EN, setting[k][1]);
			write_reg(fhfe_pkg::CFG_IPV6_EN, setting[k][0]);
			// cut just past the protocol byte, enough to reach the family check
			f = build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP,
				8'h00, 0);
			send_frame(f[0:23], 16'd60);
			f = build_frame(ENC_VLAN, fhfe_pkg::IP_VER_6, 4'd0, fhfe_pkg::PROTO_TCP,
				TCP_SYN, 0);
			send_frame(f[0:24], 16'd90);
		end
		wait_drained();
		write_reg(fhfe_pkg::CFG_IPV4_EN, 1'b1);
		write_reg(fhfe_pkg::CFG_IPV6_EN, 1'b1);
	endtask

	// sink holds off while frames keep coming, so the input must stall
	task automatic test_backpressure();
		byte_q_t f;
		hold_len = HOLD_CYCLES;
		repeat (3) begin
			f = build_frame(ENC_PLAIN, fhfe_pkg::IP_VER_4, 4'd5, fhfe_pkg::PROTO_UDP,
				8'h00, 0);
			send_frame(f[0:29], 16'd60);
		end
	endtask

	task automatic test_steady_stream();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random_traffic(60, 1);
	endtask

	initial begin
		arst_n = 1'b0;
		frame_in.valid <= 1'b0;
		frame_in.frame_byte <= '0;
		frame_in.wire_length <= '0;
		frame_in.end_of_frame <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= fhfe_pkg::CFG_IPV4_EN;
		cfg.data <= 1'b0;
		v4_en = 1'b1;
		v6_en = 1'b1;
		clear_frame_state();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(fhfe_pkg::CFG_IPV4_EN, 1'b1);
		write_reg(fhfe_pkg::CFG_IPV6_EN, 1'b1);
		test_directed_frames();
		test_family_enables();
		test_backpressure();
		test_random_traffic(80, 1);
		test_steady_stream();
		wait_drained();
		if (errors == 0)
			$display("frame_header_flow_extractor_top regression: pass");
		else
			$display("frame_header_flow_extractor_top regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/fhfe_pkg.sv
rtl/core/fhfe_if.sv
rtl/core/fhfe_parse.sv
rtl/core/fhfe_judge.sv
rtl/core/frame_header_flow_extractor_top.sv
test/tb_frame_header_flow_extractor_top.sv
